// ===== rtl/pvat_pkg.sv =====
// ----------------------------------------------------------------------------
// pvat_pkg
// Shared types, register codes and sine table helpers for the polygon vertex
// affine transform.
// ----------------------------------------------------------------------------
package pvat_pkg;

  localparam int COORD_BITS             = 16;
  localparam int TRIG_FRAC_BITS_DEFAULT = 14;
  localparam int SHIFT_BITS             = 16;
  localparam int SCALE_BITS             = 16;
  localparam int SCALE_FRAC             = 8;
  localparam int ANGLE_BITS             = 9;
  localparam int CFG_IDX_BITS           = 3;
  localparam int CFG_DATA_BITS          = 16;
  localparam int TRIG_TAB_LAST          = 90;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_PASS      = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE    = 3'd0,
    CFG_SHIFT_X = 3'd1,
    CFG_SHIFT_Y = 3'd2,
    CFG_SCALE_X = 3'd3,
    CFG_SCALE_Y = 3'd4,
    CFG_ANGLE   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    mode_t                  mode;
    logic [SHIFT_BITS-1:0]  shift_x;
    logic [SHIFT_BITS-1:0]  shift_y;
    logic [SCALE_BITS-1:0]  scale_x;
    logic [SCALE_BITS-1:0]  scale_y;
    logic [ANGLE_BITS-1:0]  angle_deg;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_in;
    logic [COORD_BITS-1:0] y_in;
    logic                  first_vertex;
    logic                  last_vertex;
  } vtx_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_out;
    logic [COORD_BITS-1:0] y_out;
    logic                  last_out;
    logic                  clamped;
  } res_item_t;

  // pi scaled by 2^30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // sin of d degrees (0..90) in Q30, Taylor series; elaboration only
  function automatic longint unsigned sin_q30(int unsigned d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return longint'(sum);
  endfunction

  // sin of d degrees rounded to fb fraction bits
  function automatic longint unsigned sin_frac(int unsigned d, int unsigned fb);
    return (sin_q30(d) + (64'd1 << (29 - fb))) >> (30 - fb);
  endfunction

endpackage

// ===== rtl/pvat_cfg.sv =====
// ----------------------------------------------------------------------------
// pvat_cfg
// Configuration register file: mode, shift, scale and angle registers.
// ----------------------------------------------------------------------------
module pvat_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pvat_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pvat_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output pvat_pkg::cfg_t                       cfg
);
  import pvat_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_TRANSLATE;
      cfg.shift_x   <= '0;
      cfg.shift_y   <= '0;
      cfg.scale_x   <= SCALE_BITS'(1 << SCALE_FRAC);
      cfg.scale_y   <= SCALE_BITS'(1 << SCALE_FRAC);
      cfg.angle_deg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:    cfg.mode      <= mode_t'(cfg_data[1:0]);
        CFG_SHIFT_X: cfg.shift_x   <= cfg_data[SHIFT_BITS-1:0];
        CFG_SHIFT_Y: cfg.shift_y   <= cfg_data[SHIFT_BITS-1:0];
        CFG_SCALE_X: cfg.scale_x   <= cfg_data[SCALE_BITS-1:0];
        CFG_SCALE_Y: cfg.scale_y   <= cfg_data[SCALE_BITS-1:0];
        CFG_ANGLE:   cfg.angle_deg <= cfg_data[ANGLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/pvat_trig.sv =====
// ----------------------------------------------------------------------------
// pvat_trig
// Sine and cosine of the configured angle from a quarter-wave table,
// registered.
// ----------------------------------------------------------------------------
module pvat_trig #(
  parameter int TRIG_FRAC_BITS = pvat_pkg::TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic [pvat_pkg::ANGLE_BITS-1:0]      angle_deg,
  output logic signed [TRIG_FRAC_BITS+1:0]     sin_q,
  output logic signed [TRIG_FRAC_BITS+1:0]     cos_q
);
  import pvat_pkg::*;

  localparam int F  = TRIG_FRAC_BITS;
  localparam int RB = $clog2(TRIG_TAB_LAST + 1);

  typedef struct packed {
    logic [RB-1:0] r;
    logic          neg;
  } fold_t;

  logic [F:0]            sin_tab [0:TRIG_TAB_LAST];
  logic [ANGLE_BITS-1:0] a_red;
  logic [ANGLE_BITS:0]   ac_sum;
  logic [ANGLE_BITS-1:0] a_cos;
  fold_t                 fs;
  fold_t                 fc;
  logic [F:0]            mag_s;
  logic [F:0]            mag_c;

  for (genvar i = 0; i <= TRIG_TAB_LAST; i++) begin : g_tab
    assign sin_tab[i] = (F + 1)'(sin_frac(i, F));
  end

  function automatic fold_t fold(logic [ANGLE_BITS-1:0] a);
    fold_t f;
    if (a <= ANGLE_BITS'(90)) begin
      f.r   = RB'(a);
      f.neg = 1'b0;
    end else if (a <= ANGLE_BITS'(180)) begin
      f.r   = RB'(ANGLE_BITS'(180) - a);
      f.neg = 1'b0;
    end else if (a <= ANGLE_BITS'(270)) begin
      f.r   = RB'(a - ANGLE_BITS'(180));
      f.neg = 1'b1;
    end else begin
      f.r   = RB'(ANGLE_BITS'(360) - a);
      f.neg = 1'b1;
    end
    return f;
  endfunction

  always_comb begin
    a_red  = (angle_deg >= ANGLE_BITS'(360)) ? angle_deg - ANGLE_BITS'(360) : angle_deg;
    ac_sum = {1'b0, a_red} + (ANGLE_BITS + 1)'(90);
    a_cos  = (ac_sum >= (ANGLE_BITS + 1)'(360)) ?
             ANGLE_BITS'(ac_sum - (ANGLE_BITS + 1)'(360)) : ANGLE_BITS'(ac_sum);
    fs     = fold(a_red);
    fc     = fold(a_cos);
    mag_s  = sin_tab[fs.r];
    mag_c  = sin_tab[fc.r];
  end

  always_ff @(posedge clk) begin
    sin_q <= fs.neg ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    cos_q <= fc.neg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
  end

endmodule

// ===== rtl/pvat_datapath.sv =====
// ----------------------------------------------------------------------------
// pvat_datapath
// Four-stage vertex pipeline: pivot and offsets, products, rounding,
// select and saturate into the result register.
// ----------------------------------------------------------------------------
module pvat_datapath #(
  parameter int TRIG_FRAC_BITS = pvat_pkg::TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pvat_pkg::cfg_t                     cfg,
  input  logic signed [TRIG_FRAC_BITS+1:0]   sin_q,
  input  logic signed [TRIG_FRAC_BITS+1:0]   cos_q,
  input  logic                               vtx_valid,
  output logic                               vtx_ready,
  input  pvat_pkg::vtx_item_t                vtx,
  output logic                               res_valid,
  input  logic                               res_ready,
  output pvat_pkg::res_item_t                res
);
  import pvat_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = TRIG_FRAC_BITS;
  localparam int DW  = C + 1;
  localparam int TW  = F + 2;
  localparam int PW  = DW + TW;
  localparam int RSW = PW + 1;
  localparam int RW  = RSW - F;
  localparam int SPW = C + SCALE_BITS;
  localparam int SRW = SPW + 1 - SCALE_FRAC;
  localparam int TSW = ((C > SHIFT_BITS) ? C : SHIFT_BITS) + 1;
  localparam int W   = SRW + 1;

  localparam logic signed [RSW-1:0] RHALF   = RSW'(1) <<< (F - 1);
  localparam logic signed [SPW:0]   SHALF   = (SPW + 1)'(1) <<< (SCALE_FRAC - 1);
  localparam logic signed [W-1:0]   SAT_HI  = {{(W - C + 1){1'b0}}, {(C - 1){1'b1}}};
  localparam logic signed [W-1:0]   SAT_LO  = ~SAT_HI;

  // stage valids and readies
  logic v0, v1, v2;
  logic r0, r1, r2, r3;

  // pivot
  logic signed [C-1:0] pivot_x, pivot_y;
  logic signed [C-1:0] px_sel, py_sel;

  // stage 0
  logic signed [C-1:0]  s0_x, s0_y, s0_px, s0_py;
  logic signed [DW-1:0] s0_dx, s0_dy;
  logic                 s0_last;

  // stage 1
  logic signed [PW-1:0]  m_xc, m_ys, m_xs, m_yc;
  logic signed [SPW-1:0] sp_x, sp_y;
  logic signed [TSW-1:0] s1_tx, s1_ty;
  logic signed [C-1:0]   s1_x, s1_y, s1_px, s1_py;
  logic                  s1_last;

  // stage 2
  logic signed [RSW-1:0] rsum_x, rsum_y;
  logic signed [SPW:0]   ssum_x, ssum_y;
  logic signed [RW-1:0]  rot_x, rot_y;
  logic signed [SRW-1:0] scl_x, scl_y;
  logic signed [TSW-1:0] s2_tx, s2_ty;
  logic signed [C-1:0]   s2_x, s2_y, s2_px, s2_py;
  logic                  s2_last;

  // stage 3
  logic signed [W-1:0] wx, wy;
  logic signed [C-1:0] ox, oy;
  logic                fx, fy;

  assign r3        = !res_valid || res_ready;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign r0        = !v0 || r1;
  assign vtx_ready = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
      pivot_x   <= '0;
      pivot_y   <= '0;
    end else begin
      if (r0) v0 <= vtx_valid;
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
      if (r3) res_valid <= v2;
      if (vtx_valid && r0 && vtx.first_vertex) begin
        pivot_x <= $signed(vtx.x_in);
        pivot_y <= $signed(vtx.y_in);
      end
    end
  end

  // the first vertex is its own pivot
  assign px_sel = vtx.first_vertex ? $signed(vtx.x_in) : pivot_x;
  assign py_sel = vtx.first_vertex ? $signed(vtx.y_in) : pivot_y;

  always_ff @(posedge clk) begin
    if (r0) begin
      s0_x    <= $signed(vtx.x_in);
      s0_y    <= $signed(vtx.y_in);
      s0_px   <= px_sel;
      s0_py   <= py_sel;
      s0_dx   <= DW'($signed(vtx.x_in)) - DW'(px_sel);
      s0_dy   <= DW'($signed(vtx.y_in)) - DW'(py_sel);
      s0_last <= vtx.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      m_xc    <= s0_dx * cos_q;
      m_ys    <= s0_dy * sin_q;
      m_xs    <= s0_dx * sin_q;
      m_yc    <= s0_dy * cos_q;
      sp_x    <= s0_x * $signed(cfg.scale_x);
      sp_y    <= s0_y * $signed(cfg.scale_y);
      s1_tx   <= TSW'(s0_x) + TSW'($signed(cfg.shift_x));
      s1_ty   <= TSW'(s0_y) + TSW'($signed(cfg.shift_y));
      s1_x    <= s0_x;
      s1_y    <= s0_y;
      s1_px   <= s0_px;
      s1_py   <= s0_py;
      s1_last <= s0_last;
    end
  end

  always_comb begin
    rsum_x = RSW'(m_xc) - RSW'(m_ys) + RHALF;
    rsum_y = RSW'(m_xs) + RSW'(m_yc) + RHALF;
    ssum_x = (SPW + 1)'(sp_x) + SHALF;
    ssum_y = (SPW + 1)'(sp_y) + SHALF;
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      rot_x   <= RW'(rsum_x >>> F);
      rot_y   <= RW'(rsum_y >>> F);
      scl_x   <= SRW'(ssum_x >>> SCALE_FRAC);
      scl_y   <= SRW'(ssum_y >>> SCALE_FRAC);
      s2_tx   <= s1_tx;
      s2_ty   <= s1_ty;
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_last <= s1_last;
    end
  end

  always_comb begin
    case (cfg.mode)
      MODE_TRANSLATE: begin
        wx = W'(s2_tx);
        wy = W'(s2_ty);
      end
      MODE_SCALE: begin
        wx = W'(scl_x);
        wy = W'(scl_y);
      end
      MODE_ROTATE: begin
        wx = W'(rot_x) + W'(s2_px);
        wy = W'(rot_y) + W'(s2_py);
      end
      default: begin
        wx = W'(s2_x);
        wy = W'(s2_y);
      end
    endcase
    fx = (wx > SAT_HI) || (wx < SAT_LO);
    fy = (wy > SAT_HI) || (wy < SAT_LO);
    ox = (wx > SAT_HI) ? C'(SAT_HI) : ((wx < SAT_LO) ? C'(SAT_LO) : C'(wx));
    oy = (wy > SAT_HI) ? C'(SAT_HI) : ((wy < SAT_LO) ? C'(SAT_LO) : C'(wy));
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      res.x_out    <= ox;
      res.y_out    <= oy;
      res.last_out <= s2_last;
      res.clamped  <= fx || fy;
    end
  end

endmodule

// ===== rtl/polygon_vertex_affine_transform.sv =====
// ----------------------------------------------------------------------------
// polygon_vertex_affine_transform
// Translate, scale or rotate a stream of polygon vertices, with rounding and
// saturation of the result.
//
//   Port group   Dir  Handshake               Payload
//   vtx          in   vtx_valid / vtx_ready   vtx_item_t
//   res          out  res_valid / res_ready   res_item_t
//   cfg          in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One vertex per cycle while the result side is not stalled; an item passes four
// registers (pivot/offset, multiply, round, select and saturate) before its
// result is valid. Sine and cosine are registered from the angle register.
// Reset is synchronous and clears the configuration registers to their
// defaults, the stage valids, and the pivot to (0, 0). A stalled result
// holds only the stages behind it that are full; empty stages keep taking
// items. cfg_ready is always high.
// ----------------------------------------------------------------------------
module polygon_vertex_affine_transform #(
  parameter int TRIG_FRAC_BITS = pvat_pkg::TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vtx_valid,
  output logic                                 vtx_ready,
  input  pvat_pkg::vtx_item_t                  vtx,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output pvat_pkg::res_item_t                  res,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pvat_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pvat_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pvat_pkg::*;

  cfg_t                             cfg;
  logic signed [TRIG_FRAC_BITS+1:0] sin_q;
  logic signed [TRIG_FRAC_BITS+1:0] cos_q;

  pvat_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pvat_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk       (clk),
    .angle_deg (cfg.angle_deg),
    .sin_q     (sin_q),
    .cos_q     (cos_q)
  );

  pvat_datapath #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sin_q     (sin_q),
    .cos_q     (cos_q),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== rtl/pvat_checker.sv =====
// ----------------------------------------------------------------------------
// pvat_checker
// Port-level checks for the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
module pvat_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vtx_valid,
  input  logic                                 vtx_ready,
  input  pvat_pkg::vtx_item_t                  vtx,
  input  logic                                 res_valid,
  input  logic                                 res_ready,
  input  pvat_pkg::res_item_t                  res,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [pvat_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pvat_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pvat_pkg::*;

  localparam int DEPTH = 4;
  localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  logic [2:0] inflight;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = vtx_valid && vtx_ready;
  assign acc_out = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(acc_in) - 3'(acc_out);
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> inflight != 3'd0)
    else $error("result item without an accepted vertex");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'(DEPTH))
    else $error("more items in flight than pipeline stages");

  a_clamp_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.clamped |->
      res.x_out == C_MAX || res.x_out == C_MIN ||
      res.y_out == C_MAX || res.y_out == C_MIN)
    else $error("clamped item without a coordinate at a limit");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind polygon_vertex_affine_transform pvat_checker u_pvat_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for polygon_vertex_affine_transform. A clocked driver
// feeds vertices from a queue with random gaps. A clocked monitor stalls the
// result side at random and checks every result against an in-bench
// transform model: translate, Q8.8 scale, rotation about the latched first
// vertex, and pass-through. The model builds its own Q14 sine table. The
// register settings change between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import pvat_pkg::*;

  localparam int TRIG_FB = TRIG_FRAC_BITS_DEFAULT;
  localparam longint unsigned PI_SCALED = 64'd3373259426;  // pi * 2^30
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int ITEM_TARGET = 1200;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     vtx_valid = 1'b0;
  logic                     vtx_ready;
  vtx_item_t                vtx = '0;
  logic                     res_valid;
  logic                     res_ready = 1'b0;
  res_item_t                res;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // register copies and pivot of the model
  mode_t            cfg_mode_q = MODE_TRANSLATE;
  logic [15:0]      cfg_shift_x_q = '0;
  logic [15:0]      cfg_shift_y_q = '0;
  logic [15:0]      cfg_scale_x_q = 16'd256;
  logic [15:0]      cfg_scale_y_q = 16'd256;
  logic [8:0]       cfg_angle_q = '0;
  longint           pivot_x = 0;
  longint           pivot_y = 0;
  longint           sine_q14 [0:359];

  vtx_item_t        vertex_q [$];
  res_item_t        expected_res_q [$];
  int               sent_total = 0;
  int               mismatch_cnt = 0;

  int               send_gap = 0;
  bit               send_burst = 1'b0;
  int               recv_stall = 0;
  bit               recv_burst = 1'b0;

  polygon_vertex_affine_transform i_dut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // sin(deg) in Q30 for deg in 0..90, Taylor series to the 17th power
  function automatic longint taylor_sine_q30(int unsigned deg);
    longint unsigned rad;
    longint unsigned rad2;
    longint unsigned term;
    longint          acc;
    rad  = (64'(deg) * PI_SCALED + 64'd90) / 64'd180;
    rad2 = (rad * rad) >> 30;
    term = rad;
    acc  = longint'(rad);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * rad2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    return acc;
  endfunction

  // round to nearest, ties up, dropping k fraction bits
  function automatic longint round_drop(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic logic [15:0] sat_coord(input longint v, output logic hit);
    hit = 1'b0;
    if (v > COORD_MAX) begin
      hit = 1'b1;
      v   = COORD_MAX;
    end else if (v < COORD_MIN) begin
      hit = 1'b1;
      v   = COORD_MIN;
    end
    return v[15:0];
  endfunction

  function automatic res_item_t transform_vertex(vtx_item_t v);
    longint      x;
    longint      y;
    longint      rx;
    longint      ry;
    longint      dx;
    longint      dy;
    longint      s;
    longint      c;
    int unsigned a;
    int unsigned ac;
    logic        hit_x;
    logic        hit_y;
    res_item_t   r;
    x = longint'($signed(v.x_in));
    y = longint'($signed(v.y_in));
    if (v.first_vertex) begin
      pivot_x = x;
      pivot_y = y;
    end
    case (cfg_mode_q)
      MODE_TRANSLATE: begin
        rx = x + longint'($signed(cfg_shift_x_q));
        ry = y + longint'($signed(cfg_shift_y_q));
      end
      MODE_SCALE: begin
        rx = round_drop(x * longint'($signed(cfg_scale_x_q)), SCALE_FRAC);
        ry = round_drop(y * longint'($signed(cfg_scale_y_q)), SCALE_FRAC);
      end
      MODE_ROTATE: begin
        a = cfg_angle_q;
        if (a >= 360) begin
          a = a - 360;
        end
        ac = a + 90;
        if (ac >= 360) begin
          ac = ac - 360;
        end
        s  = sine_q14[a];
        c  = sine_q14[ac];
        dx = x - pivot_x;
        dy = y - pivot_y;
        rx = round_drop(dx * c - dy * s, TRIG_FB) + pivot_x;
        ry = round_drop(dx * s + dy * c, TRIG_FB) + pivot_y;
      end
      default: begin
        rx = x;
        ry = y;
      end
    endcase
    r.x_out    = sat_coord(rx, hit_x);
    r.y_out    = sat_coord(ry, hit_y);
    r.last_out = v.last_vertex;
    r.clamped  = hit_x | hit_y;
    return r;
  endfunction

  function automatic logic [15:0] rand_word16();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom_range(0, 1200)) - 16'd600;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                             input bit first, input bit last);
    vtx_item_t v;
    v.x_in         = x;
    v.y_in         = y;
    v.first_vertex = first;
    v.last_vertex  = last;
    vertex_q.push_back(v);
    sent_total++;
  endtask

  task automatic write_reg(input int idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_BITS-1:0];
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:    cfg_mode_q    = mode_t'(data[1:0]);
      CFG_SHIFT_X: cfg_shift_x_q = data;
      CFG_SHIFT_Y: cfg_shift_y_q = data;
      CFG_SCALE_X: cfg_scale_x_q = data;
      CFG_SCALE_Y: cfg_scale_y_q = data;
      CFG_ANGLE:   cfg_angle_q   = data[8:0];
      default:     ;
    endcase
  endtask

  // block is idle once nothing is queued, in flight or expected
  task automatic wait_drain();
    @(negedge clk);
    while (vertex_q.size() != 0 || vtx_valid || expected_res_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      vtx_valid <= 1'b0;
    end else begin
      if (vtx_valid && vtx_ready) begin
        expected_res_q.push_back(transform_vertex(vtx));
      end
      if (!vtx_valid || vtx_ready) begin
        if (send_gap != 0) begin
          send_gap  = send_gap - 1;
          vtx_valid <= 1'b0;
        end else if (vertex_q.size() != 0) begin
          vtx       <= vertex_q.pop_front();
          vtx_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            send_burst = ~send_burst;
          end
          send_gap = send_burst ? 0 : $urandom_range(0, 7);
        end else begin
          vtx_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_item_t want;
    logic      rdy_next;
    rdy_next = res_ready;
    if (rst) begin
      rdy_next = 1'b0;
    end else if (res_valid && res_ready) begin
      if (expected_res_q.size() == 0) begin
        $error("result item with nothing expected: x_out %0d y_out %0d",
               $signed(res.x_out), $signed(res.y_out));
        mismatch_cnt++;
      end else begin
        want = expected_res_q.pop_front();
        if (res.x_out !== want.x_out) begin
          $error("x_out: expected %0d, got %0d", $signed(want.x_out), $signed(res.x_out));
          mismatch_cnt++;
        end
        if (res.y_out !== want.y_out) begin
          $error("y_out: expected %0d, got %0d", $signed(want.y_out), $signed(res.y_out));
          mismatch_cnt++;
        end
        if (res.last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, res.last_out);
          mismatch_cnt++;
        end
        if (res.clamped !== want.clamped) begin
          $error("clamped: expected %0b, got %0b", want.clamped, res.clamped);
          mismatch_cnt++;
        end
      end
      if ($urandom_range(0, 39) == 0) begin
        recv_burst = ~recv_burst;
      end
      recv_stall = recv_burst ? 0 : $urandom_range(0, 7);
      rdy_next   = (recv_stall == 0);
    end else if (!res_ready) begin
      if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
      end
      rdy_next = (recv_stall == 0);
    end
    res_ready <= rdy_next;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned fold;
    bit          neg;
    longint      mag;
    logic [15:0] mode_data;
    int          phase_len;
    int          phase_sent;
    int          poly_len;
    bit          first_phase;

    for (int a = 0; a < 360; a++) begin
      neg = 1'b0;
      if (a <= 90) begin
        fold = a;
      end else if (a <= 180) begin
        fold = 180 - a;
      end else if (a <= 270) begin
        fold = a - 180;
        neg  = 1'b1;
      end else begin
        fold = 360 - a;
        neg  = 1'b1;
      end
      mag = (taylor_sine_q30(fold) + (longint'(1) << (29 - TRIG_FB))) >>> (30 - TRIG_FB);
      sine_q14[a] = neg ? -mag : mag;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // rotate before any first vertex: pivot still at origin
    write_reg(CFG_MODE, 16'(MODE_ROTATE));
    write_reg(CFG_ANGLE, 16'd90);
    repeat (4) @(negedge clk);
    send_vertex(16'd100, 16'd0, 1'b0, 1'b0);
    send_vertex(16'h8000, 16'h8000, 1'b0, 1'b0);
    send_vertex(16'h7fff, 16'h7fff, 1'b0, 1'b0);
    send_vertex(16'd10, 16'd20, 1'b1, 1'b0);
    send_vertex(16'd20, 16'd20, 1'b0, 1'b0);
    send_vertex(16'd10, 16'd30, 1'b0, 1'b1);

    wait_drain();
    write_reg(CFG_MODE, 16'(MODE_TRANSLATE));
    write_reg(CFG_SHIFT_X, 16'h7fff);
    write_reg(CFG_SHIFT_Y, 16'h8000);
    repeat (4) @(negedge clk);
    send_vertex(16'h7fff, 16'h8000, 1'b1, 1'b0);
    send_vertex(16'h8000, 16'h7fff, 1'b0, 1'b0);
    send_vertex(16'd0, 16'd0, 1'b0, 1'b0);
    send_vertex(16'd1, 16'hffff, 1'b0, 1'b1);

    wait_drain();
    write_reg(CFG_MODE, 16'(MODE_SCALE));
    write_reg(CFG_SCALE_X, 16'h8000);
    write_reg(CFG_SCALE_Y, 16'h7fff);
    repeat (4) @(negedge clk);
    send_vertex(16'd1, 16'd1, 1'b0, 1'b0);
    send_vertex(16'hffff, 16'hffff, 1'b0, 1'b0);
    send_vertex(16'h7fff, 16'h8000, 1'b0, 1'b0);
    send_vertex(16'd128, -16'd128, 1'b0, 1'b0);
    send_vertex(16'd0, 16'd0, 1'b0, 1'b1);

    // half-unit factors hit the rounding ties
    wait_drain();
    write_reg(CFG_SCALE_X, 16'd128);
    write_reg(CFG_SCALE_Y, -16'd128);
    repeat (4) @(negedge clk);
    send_vertex(16'd1, 16'd1, 1'b0, 1'b0);
    send_vertex(16'hffff, 16'hffff, 1'b0, 1'b0);
    send_vertex(16'd3, -16'd3, 1'b0, 1'b1);

    // pass mode with stray upper bits, plus writes to unused indexes
    wait_drain();
    write_reg(CFG_MODE, 16'hfffc | 16'(MODE_PASS));
    write_reg(int'(CFG_ANGLE) + 1, 16'hffff);
    write_reg(int'(CFG_ANGLE) + 2, 16'h1234);
    repeat (4) @(negedge clk);
    send_vertex(16'h8000, 16'h7fff, 1'b1, 1'b0);
    send_vertex(16'h7fff, 16'h8000, 1'b0, 1'b1);
    send_vertex(16'd5, 16'hfffb, 1'b0, 1'b0);

    // angle past a full turn
    wait_drain();
    write_reg(CFG_MODE, 16'(MODE_ROTATE));
    write_reg(CFG_ANGLE, 16'd450);
    repeat (4) @(negedge clk);
    send_vertex(16'd50, 16'd50, 1'b1, 1'b0);
    send_vertex(16'd150, 16'd50, 1'b0, 1'b0);
    send_vertex(16'h8000, 16'h7fff, 1'b0, 1'b0);
    send_vertex(16'd511, 16'hfe01, 1'b0, 1'b1);

    first_phase = 1'b1;
    while (sent_total < ITEM_TARGET) begin
      wait_drain();
      if (first_phase || $urandom_range(0, 1) == 1) begin
        mode_data = 16'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2: mode_data[1:0] = MODE_TRANSLATE;
          3, 4, 5: mode_data[1:0] = MODE_SCALE;
          6, 7, 8: mode_data[1:0] = MODE_ROTATE;
          default: mode_data[1:0] = MODE_PASS;
        endcase
        write_reg(CFG_MODE, mode_data);
      end
      if (first_phase || $urandom_range(0, 1) == 1) begin
        write_reg(CFG_SHIFT_X, rand_word16());
      end
      if (first_phase || $urandom_range(0, 1) == 1) begin
        write_reg(CFG_SHIFT_Y, rand_word16());
      end
      if (first_phase || $urandom_range(0, 1) == 1) begin
        write_reg(CFG_SCALE_X, rand_word16());
      end
      if (first_phase || $urandom_range(0, 1) == 1) begin
        write_reg(CFG_SCALE_Y, rand_word16());
      end
      if (first_phase || $urandom_range(0, 1) == 1) begin
        mode_data = 16'($urandom);
        if ($urandom_range(0, 5) == 0) begin
          mode_data[8:0] = 9'($urandom_range(0, 511));
        end else begin
          mode_data[8:0] = 9'($urandom_range(0, 359));
        end
        write_reg(CFG_ANGLE, mode_data);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(int'(CFG_ANGLE) + 1 + $urandom_range(0, 1), 16'($urandom));
      end
      first_phase = 1'b0;
      repeat (4) @(negedge clk);

      phase_len  = $urandom_range(20, 80);
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        if ($urandom_range(0, 4) == 0) begin
          send_vertex(rand_word16(), rand_word16(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          phase_sent++;
        end else begin
          poly_len = $urandom_range(2, 8);
          for (int i = 0; i < poly_len; i++) begin
            send_vertex(rand_word16(), rand_word16(), i == 0, i == poly_len - 1);
          end
          phase_sent += poly_len;
        end
      end
    end

    wait_drain();
    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pvat_pkg.sv
rtl/pvat_cfg.sv
rtl/pvat_trig.sv
rtl/pvat_datapath.sv
rtl/polygon_vertex_affine_transform.sv
rtl/pvat_checker.sv
sim/tb_top.sv
